// File: rtl/sss_pkg.sv
// Package for the slot sample set store: sizes, command codes and the
// record types shared by the edit logic, the slot store and the top level.
// No dependencies.
package sss_pkg;

   localparam int Slots     = 16;
   localparam int SampleIds = 16;
   localparam int PerSlot   = 4;

   // Fixed field widths of the stream beats
   localparam int CmdW  = 3;
   localparam int SlotW = 4;
   localparam int IdW   = 4;
   localparam int CntW  = 3;

   // Store index width; Slots must not exceed 2**SlotW
   localparam int SlotIdxW = (Slots > 1) ? $clog2(Slots) : 1;

   localparam logic [CmdW-1:0] CmdAdd      = 3'd0;
   localparam logic [CmdW-1:0] CmdRemove   = 3'd1;
   localparam logic [CmdW-1:0] CmdClearSlot = 3'd2;
   localparam logic [CmdW-1:0] CmdQuery    = 3'd3;
   localparam logic [CmdW-1:0] CmdClearAll = 3'd4;

   typedef logic [PerSlot-1:0][IdW-1:0] row_type;
   typedef logic [CntW-1:0]             fill_type;

   // Write request from the edit logic to the slot store
   typedef struct packed {
      logic                we;
      logic                clr_all;
      logic [SlotIdxW-1:0] slot;
      row_type             row;
      fill_type            fill;
   } store_wr_type;

   // One result beat before packing
   typedef struct packed {
      logic           present;
      fill_type       count;
      logic           evicted;
      logic [IdW-1:0] evicted_sample;
   } result_type;

endpackage

// File: rtl/slot_sample_set_store_core.sv
// Top level of the slot sample set store: input stage, edit logic, slot
// store and result register. Depends on sss_pkg, sss_store, sss_slot_edit.
//
// Use:
//   Each request beat on req_* carries one command (add, remove, clear
//   slot, query, clear all) for one slot and one sample id. Every request
//   yields exactly one response beat on rsp_*: whether the id is in the
//   slot afterwards, the slot's count, and the id dropped by an add to a
//   full slot (zero if none).
// Throughput:
//   A request accepted into the input stage is registered there, then edited
//   and written to the result register when it moves on, which sets rsp_tvalid.
//   One beat per cycle is sustained while rsp_tready is high: the edit is a
//   single read-modify-write of one slot row in the flop store, done in the
//   cycle the beat moves from the input stage to the result register, so
//   the next beat always sees the updated row.
// Stall:
//   When rsp_tready is low the result register holds and the input stage
//   holds; one more request is still taken into the input stage while a
//   result waits, after that req_tready drops.
// Reset:
//   Synchronous, active high. Both stages empty and every slot count goes
//   to zero at once; the entry rows are not cleared (no clearing pass).
module slot_sample_set_store_core
   import sss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] command, [6:3] slot, [10:7] sample id, [15:11] zero
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] present, [3:1] count, [4] evicted, [8:5] evicted_sample,
   // [15:9] zero
   output logic [15:0] rsp_tdata
);

   // input stage
   logic             in_valid_ff, in_valid_in;
   logic [CmdW-1:0]  in_cmd_ff;
   logic [SlotW-1:0] in_slot_ff;
   logic [IdW-1:0]   in_id_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff;

   logic             fire;      // input stage moves into result register
   logic             req_beat;
   row_type          rd_row;
   fill_type         rd_fill;
   store_wr_type     wr;
   result_type       res;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in  = req_beat || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_cmd_ff  <= req_tdata[2:0];
         in_slot_ff <= req_tdata[6:3];
         in_id_ff   <= req_tdata[10:7];
      end
      if (fire) begin
         rsp_data_ff <= {7'd0, res.evicted_sample, res.evicted, res.count, res.present};
      end
   end

   sss_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_slot (in_slot_ff[SlotIdxW-1:0]),
      .rd_row  (rd_row),
      .rd_fill (rd_fill),
      .wr      (wr)
   );

   sss_slot_edit u_edit (
      .en     (fire),
      .cmd    (in_cmd_ff),
      .slot   (in_slot_ff),
      .smp_id (in_id_ff),
      .row    (rd_row),
      .fill   (rd_fill),
      .wr     (wr),
      .res    (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an eviction only happens on a full slot, and the new id is then present
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> (int'(rsp_tdata[3:1]) == PerSlot) && rsp_tdata[0])
      else $error("eviction reported on a slot that is not full");

   // no eviction means a zero evicted id
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> (rsp_tdata[8:5] == '0))
      else $error("evicted id nonzero without eviction");

   // stored fill never exceeds the slot capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (int'(rd_fill) <= PerSlot))
      else $error("slot fill above capacity");

   // a result is produced only from an occupied input stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff))
      else $error("response without a request");

endmodule

// File: rtl/sss_store.sv
// Slot store: one row of ids and one fill count per slot, in flops.
// Depends on sss_pkg.
module sss_store
   import sss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [SlotIdxW-1:0] rd_slot,
   output row_type             rd_row,
   output fill_type            rd_fill,
   input  store_wr_type        wr
);

   row_type  rows_ff [Slots];
   fill_type fill_ff [Slots];

   assign rd_row  = rows_ff[rd_slot];
   assign rd_fill = fill_ff[rd_slot];

   // Entry rows: no reset, only entries below the fill are ever used
   always_ff @(posedge clock) begin
      if (wr.we) begin
         rows_ff[wr.slot] <= wr.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || wr.clr_all) begin
         for (int i = 0; i < Slots; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (wr.we) begin
         fill_ff[wr.slot] <= wr.fill;
      end
   end

endmodule

// File: rtl/sss_slot_edit.sv
// Edit logic for one command: matches the id against the slot row, builds
// the new row and fill, and the result fields. Purely combinational.
// Depends on sss_pkg.
module sss_slot_edit
   import sss_pkg::*;
(
   input  logic             en,
   input  logic [CmdW-1:0]  cmd,
   input  logic [SlotW-1:0] slot,
   input  logic [IdW-1:0]   smp_id,
   input  row_type          row,
   input  fill_type         fill,
   output store_wr_type     wr,
   output result_type       res
);

   logic               slot_ok;
   logic               id_ok;
   logic [PerSlot-1:0] hit;
   logic [PerSlot-1:0] at_or_after;
   logic               found;
   row_type            new_row;
   fill_type           new_fill;

   always_comb begin
      slot_ok = int'(slot) < Slots;
      id_ok   = int'(smp_id) < SampleIds;

      for (int i = 0; i < PerSlot; i++) begin
         hit[i] = id_ok && (row[i] == smp_id) && (i < int'(fill));
      end
      found = |hit;

      // positions at or past the match close the gap on remove
      at_or_after[0] = hit[0];
      for (int i = 1; i < PerSlot; i++) begin
         at_or_after[i] = at_or_after[i-1] | hit[i];
      end

      new_row            = row;
      new_fill           = fill;
      res.present        = found;
      res.evicted        = 1'b0;
      res.evicted_sample = '0;

      case (cmd)
         CmdAdd: begin
            res.present = id_ok;
            if (id_ok && !found) begin
               if (int'(fill) < PerSlot) begin
                  for (int i = 0; i < PerSlot; i++) begin
                     if (i == int'(fill)) begin
                        new_row[i] = smp_id;
                     end
                  end
                  new_fill = fill + CntW'(1);
               end else begin
                  // full: drop the oldest, shift down, append
                  res.evicted        = 1'b1;
                  res.evicted_sample = row[0];
                  for (int i = 0; i < PerSlot - 1; i++) begin
                     new_row[i] = row[i+1];
                  end
                  new_row[PerSlot-1] = smp_id;
               end
            end
         end
         CmdRemove: begin
            if (found) begin
               for (int i = 0; i < PerSlot - 1; i++) begin
                  if (at_or_after[i]) begin
                     new_row[i] = row[i+1];
                  end
               end
               new_fill    = fill - CntW'(1);
               res.present = 1'b0;
            end
         end
         CmdClearSlot: begin
            new_fill    = '0;
            res.present = 1'b0;
         end
         CmdClearAll: begin
            new_fill    = '0;
            res.present = 1'b0;
         end
         CmdQuery: begin
         end
         default: begin
         end
      endcase

      res.count = new_fill;
      if (!slot_ok) begin
         res.present        = 1'b0;
         res.count          = '0;
         res.evicted        = 1'b0;
         res.evicted_sample = '0;
      end

      wr.we      = en && slot_ok && (cmd != CmdClearAll);
      wr.clr_all = en && (cmd == CmdClearAll);
      wr.slot    = slot[SlotIdxW-1:0];
      wr.row     = new_row;
      wr.fill    = new_fill;
   end

endmodule

// File: sim/tb.sv
// Self-checking bench for slot_sample_set_store_core: a stream driver, a response
// monitor and a behavioral predictor of the slot sets, with random flow control.
// Depends on sss_pkg and the slot_sample_set_store_core RTL.
module tb
   import sss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Codes 5..7 carry no operation and act as a query
   localparam logic [CmdW-1:0] CmdSpareLo = 3'd5;
   localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

   localparam int RandomCmds = 1900;
   localparam int CycleLimit = 200000;

   // One request beat; command sits in the low bits as on req_tdata
   typedef struct packed {
      logic [IdW-1:0]   smp_id;
      logic [SlotW-1:0] slot;
      logic [CmdW-1:0]  command;
   } edit_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   edit_cmd_type cmd_backlog[$];
   result_type   slot_reports_due[$];
   edit_cmd_type on_bus;
   int           cmds_total = 0;
   int           cmds_taken = 0;
   int           faults = 0;
   int           cycle = 0;

   // Shadow copy of the slot sets
   logic [IdW-1:0] slot_ids [Slots][PerSlot];
   int unsigned    slot_len [Slots];

   slot_sample_set_store_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int locate(logic [SlotW-1:0] s, logic [IdW-1:0] id);
      for (int i = 0; i < slot_len[s]; i++)
         if (slot_ids[s][i] == id) return i;
      return -1;
   endfunction

   // Applies one command to the shadow sets and returns the report it yields
   function automatic result_type apply_edit(edit_cmd_type c);
      result_type r;
      int pos;
      r = '0;
      pos = locate(c.slot, c.smp_id);
      case (c.command)
         CmdClearAll: begin
            foreach (slot_len[s]) slot_len[s] = 0;
         end
         CmdAdd: begin
            if (pos < 0) begin
               if (slot_len[c.slot] < PerSlot) begin
                  slot_ids[c.slot][slot_len[c.slot]] = c.smp_id;
                  slot_len[c.slot]++;
               end else begin
                  // full: oldest id drops out, the rest move down
                  r.evicted = 1'b1;
                  r.evicted_sample = slot_ids[c.slot][0];
                  for (int i = 0; i + 1 < PerSlot; i++)
                     slot_ids[c.slot][i] = slot_ids[c.slot][i+1];
                  slot_ids[c.slot][PerSlot-1] = c.smp_id;
               end
            end
         end
         CmdRemove: begin
            if (pos >= 0) begin
               for (int i = pos; i + 1 < slot_len[c.slot]; i++)
                  slot_ids[c.slot][i] = slot_ids[c.slot][i+1];
               slot_len[c.slot]--;
            end
         end
         CmdClearSlot: begin
            slot_len[c.slot] = 0;
         end
         default: ;
      endcase
      r.count = fill_type'(slot_len[c.slot]);
      r.present = (locate(c.slot, c.smp_id) >= 0);
      return r;
   endfunction

   task automatic queue_cmd(logic [CmdW-1:0] cmd, logic [SlotW-1:0] s,
                            logic [IdW-1:0] id);
      edit_cmd_type c;
      c.command = cmd;
      c.slot = s;
      c.smp_id = id;
      cmd_backlog.push_back(c);
      cmds_total++;
   endtask

   // Driver: bursts of beats with random gaps in between
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            slot_reports_due.push_back(apply_edit(on_bus));
            cmds_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               on_bus = cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, on_bus};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                           : $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: back-pressure in randomly chosen modes that each last a random time
   int ready_mode = 0;
   int ready_left = 0;
   logic toggle = 1'b0;

   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(5, 60);
      end
      ready_left--;
      toggle = ~toggle;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 5) == 0);
         default: rsp_tready <= toggle;
      endcase
   end

   // Monitor: every accepted response against the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (slot_reports_due.size() == 0) begin
            $error("unexpected response beat, tdata 0x%04h", rsp_tdata);
            faults++;
         end else begin
            want = slot_reports_due.pop_front();
            if (rsp_tdata[0] !== want.present) begin
               $error("present: expected %0d, got %0d", want.present, rsp_tdata[0]);
               faults++;
            end
            if (rsp_tdata[3:1] !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_tdata[3:1]);
               faults++;
            end
            if (rsp_tdata[4] !== want.evicted) begin
               $error("evicted: expected %0d, got %0d", want.evicted, rsp_tdata[4]);
               faults++;
            end
            if (rsp_tdata[8:5] !== want.evicted_sample) begin
               $error("evicted_sample: expected %0d, got %0d",
                      want.evicted_sample, rsp_tdata[8:5]);
               faults++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle++;
      if (cycle == CycleLimit) begin
         $display("** slot_sample_set_store_core: FAILED **");
         $finish;
      end
   end

   initial begin
      int pick;
      int hot_base, hot_span, id_base, id_span;
      logic [CmdW-1:0] cmd;
      logic [SlotW-1:0] s;
      logic [IdW-1:0] id;

      foreach (slot_len[i]) slot_len[i] = 0;

      // Fill a slot, duplicate add, evict the oldest, remove from the middle,
      // remove an absent id and the last id, then clear the slot
      queue_cmd(CmdAdd, 4'd0, 4'd0);
      queue_cmd(CmdAdd, 4'd0, 4'd15);
      queue_cmd(CmdAdd, 4'd0, 4'd5);
      queue_cmd(CmdAdd, 4'd0, 4'd10);
      queue_cmd(CmdAdd, 4'd0, 4'd5);
      queue_cmd(CmdAdd, 4'd0, 4'd7);
      queue_cmd(CmdQuery, 4'd0, 4'd15);
      queue_cmd(CmdRemove, 4'd0, 4'd5);
      queue_cmd(CmdRemove, 4'd0, 4'd3);
      queue_cmd(CmdRemove, 4'd0, 4'd7);
      queue_cmd(CmdQuery, 4'd0, 4'd7);
      queue_cmd(CmdClearSlot, 4'd0, 4'd15);
      queue_cmd(CmdQuery, 4'd0, 4'd0);
      // Top slot, spare codes act as queries
      queue_cmd(CmdAdd, 4'd15, 4'd15);
      queue_cmd(CmdAdd, 4'd15, 4'd0);
      queue_cmd(CmdSpareLo, 4'd15, 4'd15);
      queue_cmd(CmdSpareLo + 3'd1, 4'd15, 4'd0);
      queue_cmd(CmdSpareHi, 4'd15, 4'd3);
      // Clear all reports zero for the addressed slot and empties every slot
      queue_cmd(CmdAdd, 4'd9, 4'd9);
      queue_cmd(CmdClearAll, 4'd15, 4'd15);
      queue_cmd(CmdQuery, 4'd15, 4'd15);
      queue_cmd(CmdQuery, 4'd9, 4'd9);
      queue_cmd(CmdAdd, 4'd9, 4'd9);
      queue_cmd(CmdClearSlot, 4'd9, 4'd9);

      // Random segments: a few hot slots and a narrow id window so slots
      // fill up, evict and get hits on remove and query
      while (cmds_total < 24 + RandomCmds) begin
         hot_base = $urandom_range(0, 15);
         hot_span = $urandom_range(0, 3);
         id_base = $urandom_range(0, 15);
         id_span = ($urandom_range(0, 4) == 0) ? 15 : $urandom_range(3, 8);
         repeat ($urandom_range(40, 120)) begin
            pick = $urandom_range(0, 99);
            s = SlotW'((hot_base + $urandom_range(0, hot_span)) % Slots);
            id = IdW'((id_base + $urandom_range(0, id_span)) % SampleIds);
            if (pick < 48)      cmd = CmdAdd;
            else if (pick < 68) cmd = CmdRemove;
            else if (pick < 82) cmd = CmdQuery;
            else if (pick < 86) cmd = CmdClearSlot;
            else if (pick < 87) cmd = CmdClearAll;
            else if (pick < 90) cmd = CmdW'($urandom_range(CmdSpareLo, CmdSpareHi));
            else begin
               // noise: any code, any slot, any id
               cmd = CmdW'($urandom_range(0, 7));
               s = SlotW'($urandom_range(0, 15));
               id = IdW'($urandom_range(0, 15));
            end
            queue_cmd(cmd, s, id);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (cmds_taken < cmds_total) @(posedge clock);
      while (slot_reports_due.size() != 0) @(posedge clock);
      // Watch for stray beats past the pipeline depth
      repeat (10) @(posedge clock);

      if (faults == 0)
         $display("** slot_sample_set_store_core: PASSED **");
      else
         $display("** slot_sample_set_store_core: FAILED **");
      $finish;
   end

endmodule
